// ===== design/plc_pkg.sv =====
// Shared types and constants for the piecewise-linear curve block.
// No dependencies.
package plc_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_MANY    = 3'd2,
    ST_NOTINC  = 3'd3,
    ST_NOTMONO = 3'd4
  } status_e;

  localparam logic [16:0] OneQ16 = 17'h10000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [16:0]        knot_x;
    logic signed [31:0] knot_y;
    logic [16:0]        query;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_word_t;

  // Front-to-back job: either a finished word or a division to run.
  typedef struct packed {
    logic               do_div;
    out_word_t          res;
    logic signed [31:0] y0;
    logic signed [32:0] dy;
    logic [16:0]        dq;
    logic [16:0]        span;
  } job_t;

  typedef enum logic [1:0] {
    FS_IDLE   = 2'd0,
    FS_SEARCH = 2'd1,
    FS_ISSUE  = 2'd2
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_MUL  = 2'd1,
    BS_DIV  = 2'd2,
    BS_OUT  = 2'd3
  } back_state_e;

endpackage

// ===== design/plc_front.sv =====
// Front end: knot table, append checks, segment search.
// Depends on plc_pkg.
module plc_front #(
  parameter int MaxKnots = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_mono_i,
  input  logic              push_i,
  output logic              full_o,
  input  plc_pkg::in_word_t in_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output plc_pkg::job_t     job_o
);
  import plc_pkg::*;

  localparam int IW = $clog2(MaxKnots);
  localparam int CW = $clog2(MaxKnots + 1);

  logic [16:0]        xmem [MaxKnots];
  logic signed [31:0] ymem [MaxKnots];

  front_state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    fault_q, fault_d;
  logic          nondec_q, nondec_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [16:0]   qry_q, qry_d;
  logic [16:0]   prev_x_q, prev_x_d;
  logic signed [31:0] prev_y_q, prev_y_d;
  logic [16:0]        rd_x_q, seg_x_q, seg_x_d;
  logic signed [31:0] rd_y_q, seg_y_q, seg_y_d;
  job_t          job_q, job_d;
  logic          wr_en;
  logic [16:0]   sat_x;
  logic [IW-1:0] last_idx;

  assign sat_x    = (in_i.knot_x > OneQ16) ? OneQ16 : in_i.knot_x;
  assign last_idx = IW'(cnt_q - CW'(1));
  assign full_o   = (st_q != FS_IDLE);
  assign job_valid_o = (st_q == FS_ISSUE);
  assign job_o    = job_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; fault_d = fault_q; nondec_d = nondec_q;
    idx_d = idx_q; qry_d = qry_q; prev_x_d = prev_x_q; prev_y_d = prev_y_q;
    seg_x_d = seg_x_q; seg_y_d = seg_y_q;
    job_d = job_q; wr_en = 1'b0;
    unique case (st_q)
      FS_IDLE: begin
        if (push_i) begin
          job_d = '0;
          st_d  = FS_ISSUE;
          unique case (opcode_e'(in_i.opcode))
            OP_CLEAR: begin
              cnt_d = '0; fault_d = ST_OK; nondec_d = 1'b1;
            end
            OP_APPEND: begin
              priority if (fault_q != ST_OK) begin
              end else if (cnt_q >= CW'(MaxKnots)) begin
                fault_d = ST_MANY;
              end else if (cnt_q != '0 && sat_x <= prev_x_q) begin
                fault_d = ST_NOTINC;
              end else if (cnt_q != '0 && in_i.knot_y < prev_y_q && cfg_mono_i) begin
                nondec_d = 1'b0; fault_d = ST_NOTMONO;
              end else begin
                if (cnt_q != '0 && in_i.knot_y < prev_y_q) nondec_d = 1'b0;
                wr_en = 1'b1; cnt_d = cnt_q + CW'(1);
                prev_x_d = sat_x; prev_y_d = in_i.knot_y;
              end
              job_d.res.status = fault_d;
            end
            OP_EVAL: begin
              priority if (fault_q != ST_OK) begin
                job_d.res.status = fault_q;
              end else if (cnt_q < CW'(2)) begin
                job_d.res.status = ST_FEW;
              end else begin
                qry_d = in_i.query; idx_d = '0; st_d = FS_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      FS_SEARCH: begin
        // one knot per cycle: stop at first x >= q, or at the last knot;
        // rd_* holds knot idx_q, seg_* holds knot idx_q - 1
        priority if (qry_q <= rd_x_q || idx_q == last_idx) begin
          job_d = '0;
          st_d  = FS_ISSUE;
          if (idx_q == '0 || qry_q >= rd_x_q) begin
            job_d.res.value = rd_y_q;
          end else begin
            job_d.do_div = 1'b1;
            job_d.y0   = seg_y_q;
            job_d.dy   = 33'(rd_y_q) - 33'(seg_y_q);
            job_d.dq   = qry_q - seg_x_q;
            job_d.span = rd_x_q - seg_x_q;
          end
        end else begin
          idx_d   = idx_q + IW'(1);
          seg_x_d = rd_x_q;
          seg_y_d = rd_y_q;
        end
      end
      FS_ISSUE: if (job_ready_i) st_d = FS_IDLE;
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      xmem[IW'(cnt_q)] <= sat_x;
      ymem[IW'(cnt_q)] <= in_i.knot_y;
    end
    rd_x_q <= xmem[idx_d];
    rd_y_q <= ymem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FS_IDLE; cnt_q <= '0; fault_q <= ST_OK; nondec_q <= 1'b1;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; fault_q <= fault_d; nondec_q <= nondec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; qry_q <= qry_d; prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d; job_q <= job_d;
    seg_x_q <= seg_x_d; seg_y_q <= seg_y_d;
  end

  // nondecreasing flag kept as table state; not reported
  logic unused_nondec;
  assign unused_nondec = nondec_q;
endmodule

// ===== design/plc_back.sv =====
// Back end: multiply, restoring divide, result register.
// Depends on plc_pkg.
module plc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  plc_pkg::job_t      job_i,
  output logic               empty_o,
  input  logic               pop_i,
  output plc_pkg::out_word_t out_o
);
  import plc_pkg::*;

  back_state_e st_q, st_d;
  logic [49:0] num_q, num_d;      // |dy*dq| < 2^50
  logic [16:0] den_q, den_d;
  logic [17:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic signed [31:0] y0_q, y0_d;
  logic signed [32:0] dy_q, dy_d;
  logic [16:0] dq_q, dq_d;
  out_word_t   res_q, res_d;
  logic signed [50:0] prod;
  logic [17:0] trial;

  assign job_ready_o = (st_q == BS_IDLE);
  assign empty_o     = (st_q != BS_OUT);
  assign out_o       = res_q;
  assign prod  = 51'(dy_q) * 51'(signed'({1'b0, dq_q}));
  assign trial = {rem_q[16:0], num_q[49]} - {1'b0, den_q};

  always_comb begin
    st_d = st_q; num_d = num_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    neg_d = neg_q; y0_d = y0_q; dy_d = dy_q; dq_d = dq_q; res_d = res_q;
    unique case (st_q)
      BS_IDLE: if (job_valid_i) begin
        res_d = job_i.res; y0_d = job_i.y0; dy_d = job_i.dy; dq_d = job_i.dq;
        den_d = job_i.span;
        st_d  = job_i.do_div ? BS_MUL : BS_OUT;
      end
      BS_MUL: begin
        neg_d = prod[50];
        num_d = prod[50] ? 50'(-prod) : prod[49:0];
        rem_d = '0; cnt_d = 6'd50; st_d = BS_DIV;
      end
      BS_DIV: begin
        // one quotient bit per cycle, quotient shifts into num
        if (!trial[17]) begin
          rem_d = trial; num_d = {num_q[48:0], 1'b1};
        end else begin
          rem_d = {rem_q[16:0], num_q[49]}; num_d = {num_q[48:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) st_d = BS_OUT;
      end
      BS_OUT: if (pop_i) st_d = BS_IDLE;
      default: st_d = BS_IDLE;
    endcase
    if (st_q == BS_DIV && cnt_q == 6'd1) begin
      res_d.value = y0_q + 32'(neg_q ? -num_d : num_d);
      res_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BS_IDLE;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; cnt_q <= cnt_d;
    neg_q <= neg_d; y0_q <= y0_d; dy_q <= dy_d; dq_q <= dq_d; res_q <= res_d;
  end
endmodule

// ===== design/piecewise_linear_curve.sv =====
// Piecewise-linear curve evaluator: top level with front, job queue and back.
// Depends on plc_pkg, plc_front, plc_back.
//
// Push clear, append or evaluate words; each gives one result word. Clear and
// append need no search in the front end. An evaluate searches the knot
// table one knot per cycle, then hands the job over, and for an in-range
// evaluate the back end runs a multiply step and then a bit-serial restoring
// divider.
// A one-entry job register sits between the ends so the front can search the
// next query while the back divides or holds an unpopped result.
// Write the monotonic flag only while idle.
module piecewise_linear_curve #(
  parameter int MAX_KNOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  plc_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output plc_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import plc_pkg::*;

  logic  mono_q;
  logic  job_valid, job_ready;
  job_t  job;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          mono_q <= 1'b0;
    else if (cfg_valid_i) mono_q <= cfg_data_i;
  end

  plc_front #(.MaxKnots(MAX_KNOTS)) u_front (
    .clk_i, .rst_ni, .cfg_mono_i(mono_q), .push_i(push), .full_o(full),
    .in_i(in_word_i), .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  plc_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .empty_o(empty), .pop_i(pop), .out_o(out_word_o)
  );

  // a non-ok result never carries a nonzero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.status != ST_OK) |-> out_word_o.value == '0)
    else $error("error result with value");
  // status stays in its code range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_word_o.status <= ST_NOTMONO)
    else $error("bad status");
  // back end takes no job while a result waits
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !job_ready)
    else $error("result overwritten");
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for piecewise_linear_curve.
// Depends on plc_pkg and the piecewise_linear_curve RTL. A scoreboard class predicts
// every result word from the accepted input words and checks them in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plc_pkg::*;

  localparam int NumKnots   = 16;
  localparam int CycleLimit = 600000;
  localparam int DrainWait  = 120;   // evaluate: search + multiply + divide
  localparam int HoldCycles = 400;   // long receiver stall, fills the block

  // Curve predictor and queue of expected result words.
  class curve_scoreboard;
    logic [16:0]        knot_xs[NumKnots];
    logic signed [31:0] knot_ys[NumKnots];
    int                 count;
    status_e            fault;
    bit                 nondecreasing;
    bit                 monotonic;
    out_word_t          expected_q[$];
    int                 mismatches;
    int                 checked;

    function new();
      count         = 0;
      fault         = ST_OK;
      nondecreasing = 1;
      monotonic     = 0;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function logic signed [31:0] curve_at(logic [16:0] q);
      longint x0, span, y0, dy;
      if (q <= knot_xs[0]) return knot_ys[0];
      if (q >= knot_xs[count-1]) return knot_ys[count-1];
      for (int i = 1; i < count; i++) begin
        if (q <= knot_xs[i]) begin
          x0   = longint'(knot_xs[i-1]);
          span = longint'(knot_xs[i]) - x0;
          y0   = longint'(knot_ys[i-1]);
          dy   = longint'(knot_ys[i]) - y0;
          if (span <= 0) return knot_ys[i];
          return 32'(y0 + (dy * (longint'(q) - x0)) / span);
        end
      end
      return knot_ys[count-1];
    endfunction

    function void add_knot(logic [16:0] x, logic signed [31:0] y);
      if (fault != ST_OK) return;
      if (x > OneQ16) x = OneQ16;
      if (count >= NumKnots) begin
        fault = ST_MANY;
        return;
      end
      if (count > 0) begin
        if (x <= knot_xs[count-1]) begin
          fault = ST_NOTINC;
          return;
        end
        if (y < knot_ys[count-1]) begin
          nondecreasing = 0;
          if (monotonic) begin
            fault = ST_NOTMONO;
            return;
          end
        end
      end
      knot_xs[count] = x;
      knot_ys[count] = y;
      count++;
    endfunction

    // Called for every word the block accepts.
    function void note_input(in_word_t w);
      out_word_t r;
      r = '0;
      case (opcode_e'(w.opcode))
        OP_CLEAR: begin
          count         = 0;
          fault         = ST_OK;
          nondecreasing = 1;
        end
        OP_APPEND: begin
          add_knot(w.knot_x, w.knot_y);
          r.status = fault;
        end
        OP_EVAL: begin
          if (fault != ST_OK) r.status = fault;
          else if (count < 2) r.status = ST_FEW;
          else r.value = curve_at(w.query);
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result word value=%0d status=%0d",
                   got.value, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d: expected value=%0d status=%0d, got value=%0d status=%0d",
                   checked, want.value, want.status, got.value, got.status);
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      push = 0;
  logic      pop = 0;
  logic      full, empty;
  in_word_t  in_word = '0;
  out_word_t out_word;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic      cfg_data = 0;

  curve_scoreboard sb = new();
  bit  calm;           // no idling in the closing part
  bit  hold_req;       // asks the receiver for one long stall
  int  sent;
  int  cycles;
  int  cfg_writes;
  int  eval_count;

  always #6 clk_i = ~clk_i;

  piecewise_linear_curve #(.MAX_KNOTS(NumKnots)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycles, sb.expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result words are checked at the edge that pops them.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_word);
  end

  // Receiver: random pop bursts, plus one long stall on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        pop = 0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        pop = 0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      pop = 1;
    end
  end

  // Offer one word; returns after the edge that accepts it.
  task automatic send_word(opcode_e op, logic [16:0] x, logic [31:0] y, logic [16:0] q);
    in_word_t w;
    w.opcode = op;
    w.knot_x = x;
    w.knot_y = y;
    w.query  = q;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push = 0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    push    = 1;
    in_word = w;
    do @(posedge clk_i); while (full);
    sb.note_input(w);
    sent++;
    if (op == OP_EVAL) eval_count++;
    @(negedge clk_i);
  endtask

  // Register write, only once the block has drained.
  task automatic write_monotonic(bit val);
    push = 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_valid = 1;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.monotonic = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid = 0;
  endtask

  task automatic append(logic [16:0] x, logic [31:0] y);
    send_word(OP_APPEND, x, y, 17'($urandom));
  endtask

  task automatic evaluate(logic [16:0] q);
    send_word(OP_EVAL, 17'($urandom), $urandom, q);
  endtask

  task automatic clear_table();
    send_word(OP_CLEAR, 17'($urandom), $urandom, 17'($urandom));
  endtask

  // Random traffic: mostly well-formed curve builds followed by queries,
  // some broken builds, some pure noise.
  task automatic random_traffic(int n);
    int          stop_at, k, pick;
    logic [16:0] x, xlast, step;
    logic [31:0] y;
    bit          rising;
    stop_at = sent + n;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // noise, any opcode and any field value
        send_word(opcode_e'($urandom_range(0, 3)), 17'($urandom), $urandom, 17'($urandom));
      end else begin
        clear_table();
        k      = (pick < 20) ? NumKnots + $urandom_range(0, 2) : $urandom_range(1, 8);
        rising = 1'($urandom_range(0, 1));
        x      = 17'($urandom_range(0, 3000));
        y      = $urandom;
        if (rising) y = $urandom_range(0, 65535) - 32'sd2000000;
        for (int i = 0; i < k; i++) begin
          if (i > 0) begin
            step = 17'($urandom_range(1, 65536 / (k + 1)));
            if ($urandom_range(0, 19) == 0) step = 0;          // broken: repeated x
            x = x + step;
            if (i == k - 1 && $urandom_range(0, 2) == 0)
              x = 17'($urandom_range(65536, 131071));          // saturates to one
            y = rising ? y + $urandom_range(0, 400000) : $urandom;
          end
          append(x, y);
        end
        xlast = (x > OneQ16) ? OneQ16 : x;
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(0, 5))
            0:       evaluate(17'($urandom));
            1:       evaluate(17'($urandom_range(xlast, 131071)));
            default: evaluate(17'($urandom_range(0, xlast)));
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    write_monotonic(0);

    // Directed: empty table, single knot, edges of the range, extremes of y.
    evaluate(17'h1FFFF);                          // too few knots
    append(17'd0, 32'h8000_0000);
    evaluate(17'd0);                              // one knot still too few
    append(17'd32768, 32'h7FFF_FFFF);
    append(17'h1FFFF, 32'h8000_0000);             // x above one saturates, y falls
    evaluate(17'd0);
    evaluate(17'd1);
    evaluate(17'd32767);
    evaluate(17'd49152);
    evaluate(17'h1FFFF);                          // beyond last knot
    send_word(OP_NONE, 17'h1FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    append(17'd65536, 32'd5);                     // x not increasing
    append(17'd1, 32'd5);                         // sticky fault ignores this
    evaluate(17'd100);                            // evaluate with fault
    clear_table();
    for (int i = 0; i <= NumKnots; i++) append(17'(i * 4000 + 1), 32'(i * 1000));
    evaluate(17'd30000);                          // table overflowed
    clear_table();

    write_monotonic(1);
    append(17'd10, 32'd100);
    append(17'd20, 32'd99);                       // output falls, rejected
    evaluate(17'd15);
    clear_table();

    // Random part, with register changes between phases.
    random_traffic(300);
    write_monotonic(0);
    hold_req = 1;                                 // long receiver stall here
    random_traffic(300);
    write_monotonic(1);
    calm = 1;
    random_traffic(300);
    push = 0;

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("Sent %0d words (%0d evaluates), checked %0d results, %0d register writes.",
             sent, eval_count, sb.checked, cfg_writes);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
